// File: hdl/rmds_pkg.sv
// ----------------------------------------------------------------------------
// rmds_pkg
// Types and constants shared by the running mean and deviation block.
// ----------------------------------------------------------------------------
package rmds_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 16;
    localparam int FIELD_BITS  = 24;
    localparam int SUM_BITS    = 64;
    localparam int NORM_BITS   = 32;
    localparam int ROOT_BITS   = 32;
    localparam int MUL_A_BITS  = 48;
    localparam int MUL_B_BITS  = 24;

    localparam int DIV_STEPS   = SUM_BITS;
    localparam int SQRT_STEPS  = ROOT_BITS;

    localparam logic signed [FIELD_BITS-1:0] CODE_MAX =
        FIELD_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [FIELD_BITS-1:0] CODE_MIN = -CODE_MAX - FIELD_BITS'(1);
    localparam logic [SUM_BITS-1:0] QUO_LIM_NEG = 64'd1 << (SAMPLE_BITS - 1);
    localparam logic [SUM_BITS-1:0] QUO_LIM_POS = QUO_LIM_NEG - 64'd1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [FIELD_BITS-1:0] DEV_MAX = '1;
    localparam logic [FIELD_BITS-1:0] PLAIN_WEIGHT = FIELD_BITS'(256);

    localparam logic [1:0] KIND_PLAIN  = 2'd0;
    localparam logic [1:0] KIND_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQR,
        ST_SQW,
        ST_VALW,
        ST_ACC,
        ST_CHK,
        ST_DIV1,
        ST_MM,
        ST_DIV2,
        ST_SQRT,
        ST_FIN
    } t_state;

endpackage

// File: hdl/running_mean_deviation_stats.sv
// ----------------------------------------------------------------------------
// running_mean_deviation_stats
// A sample item with a deviation takes four multiply steps, two divisions and a
// root; one without a deviation ends after the first division, one with a zero
// norm before it; a clear item skips all steps; a stalled output adds its wait.
// Throughput: one item at a time; the next item is accepted the cycle after
// the result register loads. Reset: synchronous, active low; empty statistics.
// ----------------------------------------------------------------------------
module running_mean_deviation_stats (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_kind,
    input  logic signed [rmds_pkg::FIELD_BITS-1:0] i_sample,
    input  logic [15:0]                           i_weight,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [rmds_pkg::FIELD_BITS-1:0] o_mean_value,
    output logic [rmds_pkg::FIELD_BITS-1:0]       o_deviation,
    output logic signed [rmds_pkg::FIELD_BITS-1:0] o_minimum_seen,
    output logic signed [rmds_pkg::FIELD_BITS-1:0] o_maximum_seen,
    output logic                                  o_deviation_valid,
    output logic                                  o_mean_infinite,
    output logic                                  o_saturated
);
    localparam int FB = rmds_pkg::FIELD_BITS;
    localparam int SB = rmds_pkg::SAMPLE_BITS;
    localparam int UB = rmds_pkg::SUM_BITS;
    localparam int NB = rmds_pkg::NORM_BITS;
    localparam int KB = rmds_pkg::COUNT_BITS;

    rmds_pkg::t_state r_state, n_state;

    logic signed [FB-1:0] r_s, n_s;
    logic                 r_wt, n_wt;
    logic [15:0]          r_w, n_w;
    logic [UB-1:0]        r_prod;
    logic                 w_pen;
    logic signed [FB-1:0] r_min, n_min, r_max, n_max;
    logic signed [UB-1:0] r_vsum, n_vsum;
    logic [UB-1:0]        r_ssum, n_ssum;
    logic [KB-1:0]        r_cnt, n_cnt;
    logic [NB-1:0]        r_norm, n_norm;
    logic                 r_ovf, n_ovf;
    logic signed [FB-1:0] r_mean, n_mean;
    logic [FB-1:0]        r_dev, n_dev;
    logic                 r_dvalid, n_dvalid, r_inf, n_inf;
    logic                 r_ovalid, n_ovalid;
    logic signed [FB-1:0] r_o_mean, r_o_min, r_o_max;
    logic [FB-1:0]        r_o_dev;
    logic                 r_o_dvalid, r_o_inf, r_o_sat;
    logic                 w_load;

    logic [rmds_pkg::MUL_A_BITS-1:0] w_ma;
    logic [rmds_pkg::MUL_B_BITS-1:0] w_mb;
    logic [rmds_pkg::MUL_A_BITS+rmds_pkg::MUL_B_BITS-1:0] w_mp;

    logic [FB-1:0]        w_sabs, w_f, w_am;
    logic signed [FB-1:0] w_sext;
    logic signed [UB-1:0] w_term;
    logic [UB:0]          w_vs65, w_ss65;
    logic [NB:0]          w_norm33;
    logic [NB-1:0]        w_denom;
    logic [UB-1:0]        w_mag;
    logic                 w_div_start, w_div_done, w_sqrt_start, w_sqrt_done;
    logic [UB-1:0]        w_dividend, w_quo, w_rad;
    logic [rmds_pkg::ROOT_BITS-1:0] w_root;

    assign w_sext = FB'(signed'(i_sample[SB-1:0]));
    assign w_sabs = r_s[FB-1] ? FB'(-r_s) : r_s;
    assign w_am   = r_mean[FB-1] ? FB'(-r_mean) : r_mean;
    assign w_f    = r_wt ? FB'(r_w) : rmds_pkg::PLAIN_WEIGHT;
    assign w_mp   = w_ma * w_mb;
    assign w_term = r_s[FB-1] ? -signed'(r_prod) : signed'(r_prod);
    assign w_vs65 = {r_vsum[UB-1], r_vsum} + {w_term[UB-1], w_term};
    assign w_ss65 = {1'b0, r_ssum} + {1'b0, r_prod};
    assign w_norm33 = {1'b0, r_norm} + (NB+1)'(r_w);
    assign w_denom  = r_wt ? r_norm : NB'({r_cnt, 8'b0});
    assign w_mag    = r_vsum[UB-1] ? UB'(-r_vsum) : UB'(r_vsum);
    assign w_dividend = (r_state == rmds_pkg::ST_CHK) ? w_mag : r_ssum;
    assign w_rad    = (w_quo > r_prod) ? w_quo - r_prod : '0;

    rmds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_denom),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    rmds_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_rad),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    always_comb begin
        n_state = r_state;
        n_s = r_s; n_wt = r_wt; n_w = r_w;
        n_min = r_min; n_max = r_max;
        n_vsum = r_vsum; n_ssum = r_ssum; n_cnt = r_cnt; n_norm = r_norm; n_ovf = r_ovf;
        n_mean = r_mean; n_dev = r_dev; n_dvalid = r_dvalid; n_inf = r_inf;
        n_ovalid = r_ovalid;
        w_load = 1'b0;
        w_pen = 1'b0;
        w_ma = rmds_pkg::MUL_A_BITS'(w_sabs);
        w_mb = w_sabs;
        w_div_start = 1'b0;
        w_sqrt_start = 1'b0;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_state)
            rmds_pkg::ST_IDLE: begin
                if (i_valid) begin
                    case (i_kind)
                        rmds_pkg::KIND_CLEAR: begin
                            n_min = rmds_pkg::CODE_MAX; n_max = rmds_pkg::CODE_MIN;
                            n_vsum = '0; n_ssum = '0; n_cnt = '0; n_norm = '0;
                            n_ovf = 1'b0;
                            n_mean = '0; n_dev = '0; n_dvalid = 1'b1; n_inf = 1'b0;
                            n_state = rmds_pkg::ST_FIN;
                        end
                        rmds_pkg::KIND_PLAIN, rmds_pkg::KIND_WEIGHT: begin
                            n_s = w_sext;
                            n_wt = (i_kind == rmds_pkg::KIND_WEIGHT);
                            n_w = i_weight;
                            n_state = rmds_pkg::ST_SQR;
                        end
                        default: ;
                    endcase
                end
            end
            rmds_pkg::ST_SQR: begin
                w_pen = 1'b1;
                if (r_s > r_max) n_max = r_s;
                if (r_s < r_min) n_min = r_s;
                n_state = rmds_pkg::ST_SQW;
            end
            rmds_pkg::ST_SQW: begin
                w_ma = r_prod[rmds_pkg::MUL_A_BITS-1:0];
                w_mb = w_f;
                w_pen = 1'b1;
                n_state = rmds_pkg::ST_VALW;
            end
            rmds_pkg::ST_VALW: begin
                if (w_ss65[UB]) begin
                    n_ssum = '1; n_ovf = 1'b1;
                end else begin
                    n_ssum = w_ss65[UB-1:0];
                end
                w_mb = w_f;
                w_pen = 1'b1;
                n_state = rmds_pkg::ST_ACC;
            end
            rmds_pkg::ST_ACC: begin
                if (w_vs65[UB] != w_vs65[UB-1]) begin
                    n_ovf = 1'b1;
                    n_vsum = w_term[UB-1] ? {1'b1, {(UB-1){1'b0}}} : {1'b0, {(UB-1){1'b1}}};
                end else begin
                    n_vsum = signed'(w_vs65[UB-1:0]);
                end
                if (r_wt) begin
                    if (w_norm33[NB]) begin
                        n_norm = '1; n_ovf = 1'b1;
                    end else begin
                        n_norm = w_norm33[NB-1:0];
                    end
                end else if (r_cnt == rmds_pkg::COUNT_MAX) begin
                    n_ovf = 1'b1;
                end else begin
                    n_cnt = r_cnt + KB'(1);
                end
                n_state = rmds_pkg::ST_CHK;
            end
            rmds_pkg::ST_CHK: begin
                n_inf = 1'b0; n_dev = '0; n_dvalid = 1'b0;
                if (r_wt && r_norm == '0) begin
                    n_inf = 1'b1;
                    n_mean = r_vsum[UB-1] ? rmds_pkg::CODE_MIN : rmds_pkg::CODE_MAX;
                    n_state = rmds_pkg::ST_FIN;
                end else begin
                    w_div_start = 1'b1;
                    n_state = rmds_pkg::ST_DIV1;
                end
            end
            rmds_pkg::ST_DIV1: begin
                if (w_div_done) begin
                    if (r_vsum[UB-1]) begin
                        n_mean = (w_quo > rmds_pkg::QUO_LIM_NEG) ? rmds_pkg::CODE_MIN
                                                                 : -signed'(w_quo[FB-1:0]);
                    end else begin
                        n_mean = (w_quo > rmds_pkg::QUO_LIM_POS) ? rmds_pkg::CODE_MAX
                                                                 : signed'(w_quo[FB-1:0]);
                    end
                    if (r_wt ? (r_norm != NB'(r_w)) : (r_cnt > KB'(1)))
                        n_state = rmds_pkg::ST_MM;
                    else
                        n_state = rmds_pkg::ST_FIN;
                end
            end
            rmds_pkg::ST_MM: begin
                w_ma = rmds_pkg::MUL_A_BITS'(w_am);
                w_mb = w_am;
                w_pen = 1'b1;
                w_div_start = 1'b1;
                n_state = rmds_pkg::ST_DIV2;
            end
            rmds_pkg::ST_DIV2: begin
                if (w_div_done) begin
                    w_sqrt_start = 1'b1;
                    n_state = rmds_pkg::ST_SQRT;
                end
            end
            rmds_pkg::ST_SQRT: begin
                if (w_sqrt_done) begin
                    n_dev = (w_root > rmds_pkg::ROOT_BITS'(rmds_pkg::DEV_MAX))
                            ? rmds_pkg::DEV_MAX : w_root[FB-1:0];
                    n_dvalid = 1'b1;
                    n_state = rmds_pkg::ST_FIN;
                end
            end
            rmds_pkg::ST_FIN: begin
                if (!r_ovalid || i_ready) begin
                    w_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = rmds_pkg::ST_IDLE;
                end
            end
            default: n_state = rmds_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rmds_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_min    <= rmds_pkg::CODE_MAX;
            r_max    <= rmds_pkg::CODE_MIN;
            r_vsum   <= '0;
            r_ssum   <= '0;
            r_cnt    <= '0;
            r_norm   <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_min    <= n_min;
            r_max    <= n_max;
            r_vsum   <= n_vsum;
            r_ssum   <= n_ssum;
            r_cnt    <= n_cnt;
            r_norm   <= n_norm;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s; r_wt <= n_wt; r_w <= n_w;
        r_mean <= n_mean; r_dev <= n_dev; r_dvalid <= n_dvalid; r_inf <= n_inf;
        if (w_pen) r_prod <= w_mp[UB-1:0];
        if (w_load) begin
            r_o_mean   <= r_mean;
            r_o_dev    <= r_dvalid ? r_dev : '0;
            r_o_min    <= r_min;
            r_o_max    <= r_max;
            r_o_dvalid <= r_dvalid;
            r_o_inf    <= r_inf;
            r_o_sat    <= r_ovf;
        end
    end

    assign o_ready           = (r_state == rmds_pkg::ST_IDLE);
    assign o_valid           = r_ovalid;
    assign o_mean_value      = r_o_mean;
    assign o_deviation       = r_o_dev;
    assign o_minimum_seen    = r_o_min;
    assign o_maximum_seen    = r_o_max;
    assign o_deviation_valid = r_o_dvalid;
    assign o_mean_infinite   = r_o_inf;
    assign o_saturated       = r_o_sat;

    a_dev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_deviation_valid |-> o_deviation == '0)
        else $error("deviation not zero while undefined");
    a_inf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mean_infinite |->
            (o_mean_value == rmds_pkg::CODE_MAX || o_mean_value == rmds_pkg::CODE_MIN))
        else $error("infinite mean not saturated");
    a_inf_nodev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mean_infinite |-> !o_deviation_valid)
        else $error("deviation valid with zero norm");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_valid)
        else $error("result load did not hold output");
endmodule

// File: hdl/rmds_div.sv
// ----------------------------------------------------------------------------
// rmds_div
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module rmds_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rmds_pkg::SUM_BITS-1:0]    i_dividend,
    input  logic [rmds_pkg::NORM_BITS-1:0]   i_divisor,
    output logic                             o_done,
    output logic [rmds_pkg::SUM_BITS-1:0]    o_quotient
);
    localparam int CW = $clog2(rmds_pkg::DIV_STEPS);
    localparam int NB = rmds_pkg::NORM_BITS;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NB:0]   r_rem;
    logic [rmds_pkg::SUM_BITS-1:0] r_quo;
    logic [NB-1:0] r_div;
    logic [NB:0]   w_trial;
    logic [NB:0]   n_rem;
    logic          w_bit;

    always_comb begin
        w_trial = {r_rem[NB-1:0], r_quo[rmds_pkg::SUM_BITS-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_trial - {1'b0, r_div};
            w_bit = 1'b1;
        end else begin
            n_rem = w_trial;
            w_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[rmds_pkg::SUM_BITS-2:0], w_bit};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(rmds_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: hdl/rmds_sqrt.sv
// ----------------------------------------------------------------------------
// rmds_sqrt
// Integer square root, one root bit per cycle, 64-bit radicand.
// ----------------------------------------------------------------------------
module rmds_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rmds_pkg::SUM_BITS-1:0]    i_radicand,
    output logic                             o_done,
    output logic [rmds_pkg::ROOT_BITS-1:0]   o_root
);
    localparam int CW = $clog2(rmds_pkg::SQRT_STEPS);
    localparam int RB = rmds_pkg::ROOT_BITS;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [RB:0]   r_rem;
    logic [RB-1:0] r_root;
    logic [rmds_pkg::SUM_BITS-1:0] r_rad;
    logic [RB+1:0] w_cur;
    logic [RB+1:0] w_trial;
    logic [RB+1:0] w_diff;
    logic [RB:0]   n_rem;
    logic          w_bit;

    always_comb begin
        w_cur   = {r_rem[RB-1:0], r_rad[rmds_pkg::SUM_BITS-1 -: 2]};
        w_trial = {r_root, 2'b01};
        w_diff  = w_cur - w_trial;
        if (w_cur >= w_trial) begin
            n_rem = w_diff[RB:0];
            w_bit = 1'b1;
        end else begin
            n_rem = w_cur[RB:0];
            w_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_rad  <= i_radicand;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_root <= {r_root[RB-2:0], w_bit};
                r_rad  <= {r_rad[rmds_pkg::SUM_BITS-3:0], 2'b00};
                r_cnt  <= r_cnt + CW'(1);
                if (r_cnt == CW'(rmds_pkg::SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
